// ===== rtl/ct_pkg.sv =====
// Shared constants for the command-line tokenizer: characters, codes and defaults.
package ct_pkg;

    // Default sizes handed to the top-level parameters
    localparam int BUF_DEPTH_DEF = 4096;
    localparam int MAX_ARGS_DEF  = 64;

    // Field and register widths
    localparam int CHAR_W     = 8;
    localparam int POS_OUT_W  = 12;
    localparam int CNT_OUT_W  = 7;
    localparam int ERR_W      = 3;
    localparam int MAXARG_W   = 7;
    localparam int BUFBYTES_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 2'd1;

    // Register reset values
    localparam logic [MAXARG_W-1:0]   MAX_ARGS_RST     = 7'd64;
    localparam logic [BUFBYTES_W-1:0] BUFFER_BYTES_RST = 13'd4096;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

    // Line result codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_BUF_FULL  = 3'd1,
        ERR_TOO_MANY  = 3'd2,
        ERR_QUOTE     = 3'd3,
        ERR_END_ESC   = 3'd4,
        ERR_END_QUOT  = 3'd5,
        ERR_END_QESC  = 3'd6
    } t_err;

endpackage

// ===== rtl/ct_limits.sv =====
// Configuration registers and the clamped argument and buffer limits.
module ct_limits
    import ct_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int MAX_ARGS  = MAX_ARGS_DEF,
    localparam int PW = $clog2(BUF_DEPTH + 1),
    localparam int AW = $clog2(MAX_ARGS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [PW-1:0]         o_buf_limit,
    output logic [AW-1:0]         o_arg_limit
);

    localparam int CBW = (PW > BUFBYTES_W) ? PW : BUFBYTES_W;
    localparam int CAW = (AW > MAXARG_W) ? AW : MAXARG_W;

    logic [MAXARG_W-1:0]   r_max_args;
    logic [BUFBYTES_W-1:0] r_buffer_bytes;
    logic [CBW-1:0]        buf_ext;
    logic [CBW-1:0]        buf_clamp;
    logic [CAW-1:0]        arg_ext;
    logic [CAW-1:0]        arg_clamp;

    // Take register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args     <= MAX_ARGS_RST;
            r_buffer_bytes <= BUFFER_BYTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_ARGS:     r_max_args     <= i_cfg_data[MAXARG_W-1:0];
                CFG_BUFFER_BYTES: r_buffer_bytes <= i_cfg_data[BUFBYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the buffer limit to 1 .. BUF_DEPTH and the argument limit to 1 .. MAX_ARGS
    always_comb begin
        buf_ext = CBW'(r_buffer_bytes);
        if (buf_ext == '0) begin
            buf_clamp = CBW'(1);
        end else if (buf_ext > CBW'(BUF_DEPTH)) begin
            buf_clamp = CBW'(BUF_DEPTH);
        end else begin
            buf_clamp = buf_ext;
        end

        arg_ext = CAW'(r_max_args);
        if (arg_ext == '0) begin
            arg_clamp = CAW'(1);
        end else if (arg_ext > CAW'(MAX_ARGS)) begin
            arg_clamp = CAW'(MAX_ARGS);
        end else begin
            arg_clamp = arg_ext;
        end
    end

    assign o_buf_limit = buf_clamp[PW-1:0];
    assign o_arg_limit = arg_clamp[AW-1:0];

endmodule

// ===== rtl/cmdline_tokenizer.sv =====
// Top level of the shell-style command-line tokenizer.
//
// Input channel: one line byte per transaction on i_char_in (i_char_valid /
// o_char_ready); a 0 byte ends the line. Output channel: one result per input
// transaction (o_res_valid / i_res_ready) with the buffer byte written, its
// position, an argument-start flag, the running count, done and an error code.
// Configuration: i_cfg_we with i_cfg_idx 0 (max_args) or 1 (buffer_bytes),
// taken at the clock edge; write only while the block is idle.
//
// The result of a byte is shown in the cycle after it is accepted. The block takes
// one byte per clock while the receiver keeps up; the parser state, position and
// count all update in the same cycle the byte is taken, and the single output
// register is refilled in the cycle it is emptied.
// When the receiver stalls, the output register holds its result and
// o_char_ready drops until that result is taken.
// Reset (synchronous, active low) clears the parser to its initial state,
// position and count to 0, the output register to empty, and restores the
// limits to 64 arguments and 4096 bytes.
module cmdline_tokenizer
    import ct_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int MAX_ARGS  = MAX_ARGS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_char_valid,
    output logic                  o_char_ready,
    input  logic [CHAR_W-1:0]     i_char_in,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_write_valid,
    output logic [POS_OUT_W-1:0]  o_write_pos,
    output logic [CHAR_W-1:0]     o_write_byte,
    output logic                  o_arg_start,
    output logic [CNT_OUT_W-1:0]  o_arg_count,
    output logic                  o_line_done,
    output logic [ERR_W-1:0]      o_error_code
);

    localparam int PW  = $clog2(BUF_DEPTH + 1);
    localparam int AW  = $clog2(MAX_ARGS + 1);
    localparam int XPW = (PW > POS_OUT_W) ? PW : POS_OUT_W;
    localparam int XAW = (AW > CNT_OUT_W) ? AW : CNT_OUT_W;

    typedef enum logic [2:0] {
        PS_IDLE = 3'd0,
        PS_GAP  = 3'd1,
        PS_WORD = 3'd2,
        PS_ESC  = 3'd3,
        PS_QUOT = 3'd4,
        PS_QESC = 3'd5
    } t_pstate;

    logic [PW-1:0] buf_limit;
    logic [AW-1:0] arg_limit;

    t_pstate       r_state, n_state;
    logic [PW-1:0] r_wpos,  n_wpos;
    logic [AW-1:0] r_nargs, n_nargs;

    logic                 r_res_valid;
    logic                 r_write_valid, n_write_valid;
    logic [POS_OUT_W-1:0] r_write_pos,   n_write_pos;
    logic [CHAR_W-1:0]    r_write_byte,  n_write_byte;
    logic                 r_arg_start,   n_arg_start;
    logic [CNT_OUT_W-1:0] r_arg_count,   n_arg_count;
    logic                 r_line_done,   n_line_done;
    t_err                 r_err,         n_err;

    logic          take;
    logic          start, put, done;
    logic [CHAR_W-1:0] byte_val;
    t_err          err;
    t_pstate       next;
    logic [XPW-1:0] pos_ext;
    logic [XAW-1:0] cnt_ext;

    ct_limits #(
        .BUF_DEPTH(BUF_DEPTH),
        .MAX_ARGS (MAX_ARGS)
    ) u_limits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_buf_limit(buf_limit),
        .o_arg_limit(arg_limit)
    );

    // Accept while the output register is empty or being emptied
    assign o_char_ready = !r_res_valid || i_res_ready;
    assign take         = i_char_valid && o_char_ready;

    // Decode one byte against the parser state
    always_comb begin
        start    = 1'b0;
        put      = 1'b0;
        done     = 1'b0;
        byte_val = CH_NUL;
        err      = ERR_NONE;
        next     = r_state;
        case (r_state)
            PS_IDLE, PS_GAP: begin
                if (i_char_in == CH_NUL) begin
                    done = 1'b1;
                end else if (i_char_in == CH_SPACE) begin
                    next = PS_GAP;
                end else if (i_char_in == CH_BSL) begin
                    next  = PS_ESC;
                    start = 1'b1;
                end else if (i_char_in == CH_QUOTE) begin
                    next  = PS_QUOT;
                    start = 1'b1;
                end else begin
                    next     = PS_WORD;
                    start    = 1'b1;
                    put      = 1'b1;
                    byte_val = i_char_in;
                end
            end
            PS_WORD: begin
                if (i_char_in == CH_NUL) begin
                    done = 1'b1;
                    put  = 1'b1;
                end else if (i_char_in == CH_SPACE) begin
                    next = PS_GAP;
                    put  = 1'b1;
                end else if (i_char_in == CH_BSL) begin
                    next = PS_ESC;
                end else if (i_char_in == CH_QUOTE) begin
                    err = ERR_QUOTE;
                end else begin
                    put      = 1'b1;
                    byte_val = i_char_in;
                end
            end
            PS_ESC: begin
                if (i_char_in == CH_NUL) begin
                    err = ERR_END_ESC;
                end else begin
                    next     = PS_WORD;
                    put      = 1'b1;
                    byte_val = i_char_in;
                end
            end
            PS_QUOT: begin
                if (i_char_in == CH_NUL) begin
                    err = ERR_END_QUOT;
                end else if (i_char_in == CH_BSL) begin
                    next = PS_QESC;
                end else if (i_char_in == CH_QUOTE) begin
                    next = PS_GAP;
                    put  = 1'b1;
                end else begin
                    put      = 1'b1;
                    byte_val = i_char_in;
                end
            end
            PS_QESC: begin
                if (i_char_in == CH_NUL) begin
                    err = ERR_END_QESC;
                end else begin
                    next     = PS_QUOT;
                    put      = 1'b1;
                    byte_val = i_char_in;
                end
            end
            default: begin
                next = PS_IDLE;
            end
        endcase

        // Argument limit is checked before the buffer limit
        if (err == ERR_NONE && start && r_nargs >= arg_limit) begin
            err = ERR_TOO_MANY;
        end
        if (err == ERR_NONE && put && r_wpos >= buf_limit) begin
            err = ERR_BUF_FULL;
        end
    end

    // Form the next state and the result
    always_comb begin
        n_nargs = start ? r_nargs + AW'(1) : r_nargs;
        n_wpos  = put ? r_wpos + PW'(1) : r_wpos;
        n_state = next;
        pos_ext = XPW'(r_wpos);
        cnt_ext = XAW'(n_nargs);

        n_write_valid = put;
        n_write_pos   = (put || start) ? pos_ext[POS_OUT_W-1:0] : '0;
        n_write_byte  = put ? byte_val : CH_NUL;
        n_arg_start   = start;
        n_arg_count   = cnt_ext[CNT_OUT_W-1:0];
        n_line_done   = done;
        n_err         = err;

        if (err != ERR_NONE) begin
            n_write_valid = 1'b0;
            n_write_pos   = '0;
            n_write_byte  = CH_NUL;
            n_arg_start   = 1'b0;
            n_arg_count   = '0;
            n_line_done   = 1'b0;
        end

        // Return to the initial state after done or any error
        if (err != ERR_NONE || done) begin
            n_state = PS_IDLE;
            n_wpos  = '0;
            n_nargs = '0;
        end
    end

    // Hold parser state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PS_IDLE;
            r_wpos      <= '0;
            r_nargs     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (take) begin
                r_state       <= n_state;
                r_wpos        <= n_wpos;
                r_nargs       <= n_nargs;
                r_write_valid <= n_write_valid;
                r_write_pos   <= n_write_pos;
                r_write_byte  <= n_write_byte;
                r_arg_start   <= n_arg_start;
                r_arg_count   <= n_arg_count;
                r_line_done   <= n_line_done;
                r_err         <= n_err;
                r_res_valid   <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_write_valid = r_write_valid;
    assign o_write_pos   = r_write_pos;
    assign o_write_byte  = r_write_byte;
    assign o_arg_start   = r_arg_start;
    assign o_arg_count   = r_arg_count;
    assign o_line_done   = r_line_done;
    assign o_error_code  = r_err;

endmodule
